/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the JSON string unescaper checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, off while rst_n is low.
`define JSU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define JSU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
// ---------------------------------------------------------------------------
// jsu_pkg
// Types, codes and decode helpers shared by the JSON string unescaper.
// ---------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] BSLASH_BYTE = 8'h5c;
  localparam logic [7:0] U_BYTE      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT  = 8'h20;
  localparam logic [15:0] ASCII_MAX  = 16'h007f;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } jsu_phase_t;

  typedef enum logic [1:0] {
    ST_BUSY   = 2'd0,
    ST_CLOSED = 2'd1,
    ST_ERROR  = 2'd2
  } jsu_status_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_EXP_QUOTE   = 4'd1,
    ERR_INC_ESC     = 4'd2,
    ERR_INC_UNI     = 4'd3,
    ERR_BAD_HEX     = 4'd4,
    ERR_ABOVE_ASCII = 4'd5,
    ERR_BAD_ESC     = 4'd6,
    ERR_CTRL        = 4'd7,
    ERR_UNTERM      = 4'd8
  } jsu_err_t;

  typedef struct packed {
    logic       opcode;   // 1 = end of text
    logic [7:0] in_byte;
  } jsu_item_t;

  typedef struct packed {
    jsu_err_t    error_code;
    jsu_status_t status;
    logic [7:0]  out_byte;
    logic        byte_valid;
  } jsu_result_t;

  // {ok, value} for an ASCII hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // {ok, decoded byte} for the letter after a backslash
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h22:   r = {1'b1, 8'h22};
      8'h5c:   r = {1'b1, 8'h5c};
      8'h2f:   r = {1'b1, 8'h2f};
      8'h62:   r = {1'b1, 8'h08};
      8'h66:   r = {1'b1, 8'h0c};
      8'h6e:   r = {1'b1, 8'h0a};
      8'h72:   r = {1'b1, 8'h0d};
      8'h74:   r = {1'b1, 8'h09};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/jsu_pipe_reg.sv */
// ---------------------------------------------------------------------------
// jsu_pipe_reg
// Single-entry valid/ready register stage, full rate when the sink is ready.
// ---------------------------------------------------------------------------
module jsu_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign s_ready = !valid_r || m_ready;
  assign m_valid = valid_r;
  assign m_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s_ready) begin
      valid_r <= s_valid;
    end
  end

  // load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

endmodule

/* rtl/jsu_decode.sv */
// ---------------------------------------------------------------------------
// jsu_decode
// Parser state and per-byte decode of one quoted JSON string.
// ---------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  jsu_item_t   item,
  output jsu_result_t result
);

  jsu_phase_t  phase_r, phase_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] hex_accum_r, hex_accum_nxt;

  logic [4:0]  nib;
  logic [8:0]  esc;
  logic [15:0] acc_shift;
  jsu_err_t    err;

  assign nib       = hex_nibble(item.in_byte);
  assign esc       = simple_escape(item.in_byte);
  assign acc_shift = {hex_accum_r[11:0], nib[3:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hex_count_r <= 2'd0;
      hex_accum_r <= 16'd0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      hex_count_r <= hex_count_nxt;
      hex_accum_r <= hex_accum_nxt;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    hex_count_nxt     = hex_count_r;
    hex_accum_nxt     = hex_accum_r;
    err               = ERR_NONE;
    result.byte_valid = 1'b0;
    result.out_byte   = 8'd0;
    result.status     = ST_BUSY;
    case (phase_r)
      PH_BODY: begin
        if (item.opcode) begin
          err = ERR_UNTERM;
        end else if (item.in_byte == QUOTE_BYTE) begin
          result.status = ST_CLOSED;
          phase_nxt     = PH_IDLE;
        end else if (item.in_byte == BSLASH_BYTE) begin
          phase_nxt = PH_ESC;
        end else if (item.in_byte < CTRL_LIMIT) begin
          err = ERR_CTRL;
        end else begin
          result.byte_valid = 1'b1;
          result.out_byte   = item.in_byte;
        end
      end
      PH_ESC: begin
        if (item.opcode) begin
          err = ERR_INC_ESC;
        end else if (item.in_byte == U_BYTE) begin
          phase_nxt     = PH_HEX;
          hex_count_nxt = 2'd0;
          hex_accum_nxt = 16'd0;
        end else if (!esc[8]) begin
          err = ERR_BAD_ESC;
        end else begin
          result.byte_valid = 1'b1;
          result.out_byte   = esc[7:0];
          phase_nxt         = PH_BODY;
        end
      end
      PH_HEX: begin
        if (item.opcode) begin
          err = ERR_INC_UNI;
        end else if (!nib[4]) begin
          err = ERR_BAD_HEX;
        end else begin
          hex_accum_nxt = acc_shift;
          if (hex_count_r == 2'd3) begin
            hex_count_nxt = 2'd0;
            if (acc_shift > ASCII_MAX) begin
              err = ERR_ABOVE_ASCII;
            end else begin
              result.byte_valid = 1'b1;
              result.out_byte   = acc_shift[7:0];
              phase_nxt         = PH_BODY;
            end
          end else begin
            hex_count_nxt = hex_count_r + 2'd1;
          end
        end
      end
      default: begin
        if (!item.opcode && item.in_byte == QUOTE_BYTE) begin
          phase_nxt = PH_BODY;
        end else begin
          err = ERR_EXP_QUOTE;
        end
      end
    endcase
    // any error drops the output byte and returns to idle
    if (err != ERR_NONE) begin
      result.status     = ST_ERROR;
      result.byte_valid = 1'b0;
      result.out_byte   = 8'd0;
      phase_nxt         = PH_IDLE;
      hex_count_nxt     = 2'd0;
      hex_accum_nxt     = 16'd0;
    end
    result.error_code = err;
  end

endmodule

/* rtl/json_string_unescape.sv */
// ---------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for one quoted JSON string, one byte per item.
// ---------------------------------------------------------------------------
//
//  channel | ports                          | carries
//  --------+--------------------------------+---------------------------------
//  input   | in_tvalid in_tready in_tdata   | text byte; in_tuser = end of text
//          | in_tuser                       |
//  result  | out_tvalid out_tready out_tdata| out_byte, status, error_code;
//          | out_tuser                      | out_tuser = byte_valid
//
//  One item per clock sustained while out_tready stays high; each input
//  item yields exactly one result. An item passes the input register, then
//  the decode logic feeding the result register.
//  The parser state (phase, hex digit count, hex value) advances only when
//  the item in the input register moves into the result register.
//  A stall on out_tready holds the result register and backs up into the
//  input register; the input side keeps accepting while either stage is free.
//  rst_n (synchronous, active low) empties both stages and puts the parser
//  back to waiting for an opening quote.
//
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] opcode (1 = end of text)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status,
                                  // [13:10] error_code, [15:14] zero
  output logic        out_tuser   // [0] byte_valid
);

  localparam int ItemW = $bits(jsu_item_t);
  localparam int ResW  = $bits(jsu_result_t);

  jsu_item_t   in_item;
  jsu_item_t   dec_item;
  logic        dec_valid;
  logic        dec_ready;
  jsu_result_t dec_result;
  jsu_result_t out_result;

  assign in_item.opcode  = in_tuser;
  assign in_item.in_byte = in_tdata;

  // input register
  jsu_pipe_reg #(.W(ItemW)) u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_item),
    .m_valid (dec_valid),
    .m_ready (dec_ready),
    .m_data  (dec_item)
  );

  // decode the registered byte; state moves with the item
  jsu_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (dec_valid && dec_ready),
    .item   (dec_item),
    .result (dec_result)
  );

  // result register
  jsu_pipe_reg #(.W(ResW)) u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (dec_valid),
    .s_ready (dec_ready),
    .s_data  (dec_result),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_result)
  );

  assign out_tuser = out_result.byte_valid;
  assign out_tdata = {2'b00, out_result.error_code, out_result.status,
                      out_result.out_byte};

endmodule

/* rtl/jsu_checker.sv */
// ---------------------------------------------------------------------------
// jsu_checker
// Port-level checks on the JSON string unescaper, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  logic       res_err;
  logic       res_code;
  logic       res_quiet;

  assign res_err   = (out_tdata[9:8] == ST_ERROR);
  assign res_code  = (out_tdata[13:10] != ERR_NONE);
  assign res_quiet = (out_tdata[13:8] == 6'd0);

  `JSU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  `JSU_ASSERT(a_err_code, clk, rst_n, out_tvalid |-> (res_err == res_code) && (out_tdata[9:8] != 2'd3) && (out_tdata[13:10] <= ERR_UNTERM) && (out_tdata[15:14] == 2'd0), "status and error code disagree")

  `JSU_ASSERT(a_byte_clean, clk, rst_n, out_tvalid && out_tuser |-> res_quiet, "decoded byte carries status")

  `JSU_ASSERT(a_no_byte_zero, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0, "byte nonzero without byte_valid")

  `JSU_ASSERT_ALWAYS(a_reset_empty, clk, !$past(rst_n) |-> !out_tvalid, "result valid right after reset")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming JSON string decoder.
// A table of directed items covers the idle, body, escape and \u paths and
// every error code. About seven hundred random items follow: mostly
// well-formed strings with random content, plus broken strings and noise.
// Each accepted item runs through a local decoder model, and each result is
// compared field by field with the oldest prediction. Both sides idle at
// random, and one long receiver stall backs the block up.
// ---------------------------------------------------------------------------
module tb;
  import jsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 700;
  localparam int HOLD_CYCLES = 400;     // long receiver stall
  localparam int TAIL_CYCLES = 8;       // two-stage pipe, plus margin
  localparam int CYCLE_LIMIT = 200000;

  // one row of the directed table; want is used only when typed is set
  typedef struct {
    logic        eot;
    logic [7:0]  c;
    bit          typed;
    jsu_result_t want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] in_byte
  logic        in_tuser   = 1'b0;   // [0] opcode (1 = end of text)
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] out_byte, [9:8] status,
                                    // [13:10] error_code, [15:14] zero
  logic        out_tuser;           // [0] byte_valid

  // local copy of the decoder state
  jsu_phase_t  dec_phase = PH_IDLE;
  logic [1:0]  dec_digits = 2'd0;
  logic [15:0] dec_code = 16'h0000;

  jsu_result_t decoded_q[$];
  stim_row_t   stim_tab[$];

  int     mismatches = 0;
  int     n_items = 0;
  int     n_chars = 0;
  int     n_closed = 0;
  int     n_strings = 0;
  logic [8:0] err_hits = '0;
  int     cycles = 0;

  int     send_idle_pct = 6;
  int     recv_idle_pct = 61;
  int     hold_seq = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  json_string_unescape dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited",
               cycles, decoded_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Decoder model
  // -------------------------------------------------------------------------

  // value of an ASCII hex digit, or -1
  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // byte that a simple escape letter stands for, or -1
  function automatic int esc_target(input logic [7:0] c);
    case (c)
      QUOTE_BYTE:  return 'h22;
      BSLASH_BYTE: return 'h5c;
      8'h2f:       return 'h2f;   // solidus
      8'h62:       return 'h08;   // b
      8'h66:       return 'h0c;   // f
      8'h6e:       return 'h0a;   // n
      8'h72:       return 'h0d;   // r
      8'h74:       return 'h09;   // t
      default:     return -1;
    endcase
  endfunction

  function automatic jsu_result_t outcome(input logic v, input logic [7:0] b,
                                          input jsu_status_t st,
                                          input jsu_err_t err);
    jsu_result_t r;
    r.byte_valid = v;
    r.out_byte   = b;
    r.status     = st;
    r.error_code = err;
    return r;
  endfunction

  // advance the local decoder by one item and return the result it owes
  function automatic jsu_result_t decode_item(input logic eot,
                                              input logic [7:0] c);
    jsu_result_t r;
    int nib;
    int esc;
    r = outcome(1'b0, 8'h00, ST_BUSY, ERR_NONE);
    case (dec_phase)
      PH_BODY: begin
        if (eot) r.error_code = ERR_UNTERM;
        else if (c == QUOTE_BYTE) begin
          r.status  = ST_CLOSED;
          dec_phase = PH_IDLE;
        end else if (c == BSLASH_BYTE) dec_phase = PH_ESC;
        else if (c < CTRL_LIMIT) r.error_code = ERR_CTRL;
        else begin
          r.byte_valid = 1'b1;
          r.out_byte   = c;
        end
      end
      PH_ESC: begin
        esc = esc_target(c);
        if (eot) r.error_code = ERR_INC_ESC;
        else if (c == U_BYTE) begin
          dec_phase  = PH_HEX;
          dec_digits = 2'd0;
          dec_code   = 16'h0000;
        end else if (esc < 0) r.error_code = ERR_BAD_ESC;
        else begin
          r.byte_valid = 1'b1;
          r.out_byte   = esc[7:0];
          dec_phase    = PH_BODY;
        end
      end
      PH_HEX: begin
        nib = hex_val(c);
        if (eot) r.error_code = ERR_INC_UNI;
        else if (nib < 0) r.error_code = ERR_BAD_HEX;
        else begin
          dec_code = {dec_code[11:0], nib[3:0]};
          if (dec_digits == 2'd3) begin
            // the fourth digit settles the code point
            if (dec_code > ASCII_MAX) r.error_code = ERR_ABOVE_ASCII;
            else begin
              r.byte_valid = 1'b1;
              r.out_byte   = dec_code[7:0];
              dec_phase    = PH_BODY;
            end
          end
          dec_digits = dec_digits + 2'd1;
        end
      end
      default: begin
        if (!eot && c == QUOTE_BYTE) dec_phase = PH_BODY;
        else r.error_code = ERR_EXP_QUOTE;
      end
    endcase
    // any error drops the string and goes back to hunting for a quote
    if (r.error_code != ERR_NONE) begin
      r.status     = ST_ERROR;
      dec_phase    = PH_IDLE;
      dec_digits   = 2'd0;
      dec_code     = 16'h0000;
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------

  // offer one item, hold it until taken, then log what it must produce
  task automatic push_item(input logic eot, input logic [7:0] c,
                           input bit typed = 1'b0,
                           input jsu_result_t want = '0);
    jsu_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= eot;
    in_tdata  <= c;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    r = decode_item(eot, c);
    if (typed) r = want;
    decoded_q = {decoded_q, r};
    n_items++;
    if (r.byte_valid) n_chars++;
    if (r.status == ST_CLOSED) n_closed++;
    if (r.status == ST_ERROR) err_hits[r.error_code] = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] c);
    push_item(1'b0, c);
  endtask

  // end-of-text marker; the byte lane carries junk to prove it is ignored
  task automatic send_end();
    push_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // drop valid and hold until every result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic send_hex(input logic [15:0] v, input int ndig);
    for (int i = 0; i < ndig; i++) send_byte(hex_char(v[15 - 4*i -: 4]));
  endtask

  // one legal string element: plain byte, simple escape or ASCII \u escape
  task automatic send_piece();
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    if (k < 6) begin
      do c = 8'($urandom_range('h20, 'hff));
      while (c == QUOTE_BYTE || c == BSLASH_BYTE);
      send_byte(c);
    end else if (k < 8) begin
      send_byte(BSLASH_BYTE);
      do c = 8'($urandom_range(0, 255)); while (esc_target(c) < 0);
      send_byte(c);
    end else begin
      send_byte(BSLASH_BYTE);
      send_byte(U_BYTE);
      send_hex(16'($urandom_range(0, 'h7f)), 4);
    end
  endtask

  task automatic send_string(input int npieces);
    n_strings++;
    send_byte(QUOTE_BYTE);
    repeat (npieces) send_piece();
    send_byte(QUOTE_BYTE);
  endtask

  // a string that goes wrong after a legal prefix
  task automatic send_broken();
    logic [7:0] c;
    n_strings++;
    send_byte(QUOTE_BYTE);
    repeat ($urandom_range(0, 5)) send_piece();
    case ($urandom_range(0, 6))
      0: send_end();
      1: send_byte(8'($urandom_range(0, 'h1f)));
      2: begin
        send_byte(BSLASH_BYTE);
        send_end();
      end
      3: begin
        send_byte(BSLASH_BYTE);
        do c = 8'($urandom_range(0, 255));
        while (c == U_BYTE || esc_target(c) >= 0);
        send_byte(c);
      end
      4: begin
        send_byte(BSLASH_BYTE);
        send_byte(U_BYTE);
        send_hex(16'($urandom), $urandom_range(0, 3));
        send_end();
      end
      5: begin
        send_byte(BSLASH_BYTE);
        send_byte(U_BYTE);
        send_hex(16'($urandom), $urandom_range(0, 3));
        do c = 8'($urandom_range(0, 255)); while (hex_val(c) >= 0);
        send_byte(c);
      end
      default: begin
        send_byte(BSLASH_BYTE);
        send_byte(U_BYTE);
        send_hex(16'($urandom_range('h80, 'hffff)), 4);
      end
    endcase
  endtask

  // raw bytes and end markers with no structure at all
  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 7) == 0) send_end();
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic row(input logic eot, input logic [7:0] c);
    stim_row_t s;
    s.eot   = eot;
    s.c     = c;
    s.typed = 1'b0;
    s.want  = '0;
    stim_tab = {stim_tab, s};
  endtask

  task automatic row_chk(input logic eot, input logic [7:0] c,
                         input jsu_result_t want);
    stim_row_t s;
    s.eot   = eot;
    s.c     = c;
    s.typed = 1'b1;
    s.want  = want;
    stim_tab = {stim_tab, s};
  endtask

  // -------------------------------------------------------------------------
  // Result side
  // -------------------------------------------------------------------------

  // receiver: random backpressure, or a long stall on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin
    jsu_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        exp_r = decoded_q.pop_front();
        if (out_tuser !== exp_r.byte_valid) begin
          $error("byte_valid: expected %0d, got %0d", exp_r.byte_valid, out_tuser);
          mismatches++;
        end
        if (out_tdata[7:0] !== exp_r.out_byte) begin
          $error("out_byte: expected %h, got %h", exp_r.out_byte, out_tdata[7:0]);
          mismatches++;
        end
        if (out_tdata[9:8] !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tdata[9:8]);
          mismatches++;
        end
        if (out_tdata[13:10] !== exp_r.error_code) begin
          $error("error_code: expected %0d, got %0d",
                 exp_r.error_code, out_tdata[13:10]);
          mismatches++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------

  initial begin
    jsu_result_t opened;
    int dir_n;
    int mode;
    int k;

    opened = outcome(1'b0, 8'h00, ST_BUSY, ERR_NONE);

    // idle: end marker, then the lowest byte, both rejected
    row_chk(1'b1, 8'hff, outcome(1'b0, 8'h00, ST_ERROR, ERR_EXP_QUOTE));
    row_chk(1'b0, 8'h00, outcome(1'b0, 8'h00, ST_ERROR, ERR_EXP_QUOTE));
    // top byte passes through, a newline escape, then a clean close
    row_chk(1'b0, QUOTE_BYTE, opened);
    row_chk(1'b0, 8'hff, outcome(1'b1, 8'hff, ST_BUSY, ERR_NONE));
    row(1'b0, BSLASH_BYTE);
    row(1'b0, 8'h6e);
    row_chk(1'b0, QUOTE_BYTE, outcome(1'b0, 8'h00, ST_CLOSED, ERR_NONE));
    // raw control byte in the body
    row_chk(1'b0, QUOTE_BYTE, opened);
    row_chk(1'b0, 8'h1f, outcome(1'b0, 8'h00, ST_ERROR, ERR_CTRL));
    // \uFFFf: largest code point, rejected at the fourth digit
    row(1'b0, QUOTE_BYTE);
    row(1'b0, BSLASH_BYTE);
    row(1'b0, U_BYTE);
    row(1'b0, 8'h46);
    row(1'b0, 8'h46);
    row(1'b0, 8'h46);
    row_chk(1'b0, 8'h66, outcome(1'b0, 8'h00, ST_ERROR, ERR_ABOVE_ASCII));
    // a quote where a hex digit belongs
    row(1'b0, QUOTE_BYTE);
    row(1'b0, BSLASH_BYTE);
    row(1'b0, U_BYTE);
    row_chk(1'b0, QUOTE_BYTE, outcome(1'b0, 8'h00, ST_ERROR, ERR_BAD_HEX));
    // unknown escape letter
    row(1'b0, QUOTE_BYTE);
    row(1'b0, BSLASH_BYTE);
    row_chk(1'b0, 8'h78, outcome(1'b0, 8'h00, ST_ERROR, ERR_BAD_ESC));
    // end of text after a backslash, inside \u, and in the body
    row(1'b0, QUOTE_BYTE);
    row(1'b0, BSLASH_BYTE);
    row_chk(1'b1, 8'h00, outcome(1'b0, 8'h00, ST_ERROR, ERR_INC_ESC));
    row(1'b0, QUOTE_BYTE);
    row(1'b0, BSLASH_BYTE);
    row(1'b0, U_BYTE);
    row_chk(1'b1, 8'h00, outcome(1'b0, 8'h00, ST_ERROR, ERR_INC_UNI));
    row(1'b0, QUOTE_BYTE);
    row_chk(1'b1, 8'h00, outcome(1'b0, 8'h00, ST_ERROR, ERR_UNTERM));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender rarely idles, receiver often stalls
    foreach (stim_tab[i]) begin
      push_item(stim_tab[i].eot, stim_tab[i].c, stim_tab[i].typed,
                stim_tab[i].want);
    end
    dir_n = n_items;

    mode = 0;
    while (n_items < dir_n + RAND_ITEMS) begin
      if (mode == 0 && n_items >= dir_n + RAND_ITEMS / 3) begin
        // swap: sender idles often, receiver rarely
        wait_drain();
        mode = 1;
        send_idle_pct = 61;
        recv_idle_pct <= 6;
      end else if (mode == 1 && n_items >= dir_n + 2 * RAND_ITEMS / 3) begin
        // no idling; stall the receiver while a long string keeps coming
        wait_drain();
        mode = 2;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_seq <= hold_seq + 1;
        send_string(20);
        wait_drain();
      end
      k = $urandom_range(0, 9);
      if (k < 6) send_string($urandom_range(0, 12));
      else if (k < 9) send_broken();
      else send_noise();
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d items over %0d strings: %0d decoded bytes, %0d closed strings,",
             n_items, n_strings, n_chars, n_closed);
    $display("  %0d of 8 error codes seen, one long receiver stall", $countones(err_hits));
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_pipe_reg.sv
rtl/jsu_decode.sv
rtl/json_string_unescape.sv
rtl/jsu_checker.sv
tb/tb.sv
